// ===== src/pwm_period_duty_to_counts_unit_macros.svh =====
// ----------------------------------------------------------------------------
// PWM counts unit assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PWM_PERIOD_DUTY_TO_COUNTS_UNIT_MACROS_SVH
`define PWM_PERIOD_DUTY_TO_COUNTS_UNIT_MACROS_SVH

// same-cycle implication
`define PDC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM counts package
// Widths, constants, status codes and inter-stage types.
// ----------------------------------------------------------------------------
package pdc_pkg;

	localparam int COUNT_BITS = 12;
	localparam int PER_W      = 31;
	localparam int TICK_W     = 30;
	localparam int PROD_W     = 61;
	localparam int DIV_STEPS  = TICK_W;
	localparam int CLK_W      = 8;
	localparam int TOP_W      = 5;

	localparam logic [CLK_W-1:0] CLK_RESET = 8'd96;
	localparam logic [PER_W-1:0] NS_PER_US = 31'd1000;

	// APB byte address of input_clock_mhz
	localparam logic [1:0] ADDR_CLK_MHZ = 2'd0;

	// period / 1000 as multiply by ceil(2^38 / 1000)
	localparam logic [28:0] M_LONG   = 29'd274877907;
	// (period * clk) / 1000 for short periods, ceil(2^28 / 1000)
	localparam logic [18:0] M_SHORT  = 19'd268436;

	localparam int HIGH_POS  = 20;
	localparam int LOW_POS   = 8;
	localparam int SHIFT_POS = 4;
	localparam logic [TOP_W-1:0] MAX_SHIFT = 5'd15;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic              valid;
		logic              invalid;
		logic [PER_W-1:0]  period;
		logic [PER_W-1:0]  duty;
		logic [TICK_W-1:0] ticks;
	} pdc_tick_t;

	typedef struct packed {
		logic              valid;
		logic              invalid;
		logic [TICK_W-1:0] ticks;
		logic [TICK_W-1:0] high;
	} pdc_quo_t;

	// 1-based index of the highest set bit, zero for zero
	function automatic logic [TOP_W-1:0] top_bit(input logic [TICK_W-1:0] v);
		logic [TOP_W-1:0] n;
		n = '0;
		for (int i = 0; i < TICK_W; i++) begin
			if (v[i]) n = TOP_W'(i + 1);
		end
		return n;
	endfunction

endpackage

// ===== src/pwm_period_duty_to_counts_unit.sv =====
// ----------------------------------------------------------------------------
// PWM period/duty to counts unit
// Converts period and duty in ns into prescaled PWM counter settings.
// ----------------------------------------------------------------------------
// Input word: period_time_ns and duty_time_ns, taken when in_valid is high
// and in_stall is low. Output word: status, control_word, high_count,
// low_count and prescale_shift, taken when out_valid is high and out_stall
// is low. One word is accepted every cycle while in_stall is low. Three
// stages form the tick count, two form ticks times duty, thirty divider
// stages each produce one bit of the high count, and two stages search
// the shift and pack the word.
// input_clock_mhz sits at APB offset 0; write it only while no word is in
// flight. Reset empties the pipeline and sets the clock register to 96.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "pwm_period_duty_to_counts_unit_macros.svh"

module pwm_period_duty_to_counts_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [1:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pdc_pkg::PER_W-1:0]         period_time_ns,
	input  logic [pdc_pkg::PER_W-1:0]         duty_time_ns,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [31:0]                       control_word,
	output logic [11:0]                       high_count,
	output logic [11:0]                       low_count,
	output logic [3:0]                        prescale_shift
);

	logic [pdc_pkg::CLK_W-1:0] clk_mhz_q;
	logic advance;
	logic err_clear, fields_match;
	pdc_pkg::pdc_tick_t tk;
	pdc_pkg::pdc_quo_t  qo;

	assign pready  = 1'b1;
	assign prdata  = (paddr == pdc_pkg::ADDR_CLK_MHZ) ? 32'(clk_mhz_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_mhz_q <= pdc_pkg::CLK_RESET;
		end else if (psel && penable && pwrite && pready) begin
			clk_mhz_q <= pwdata[pdc_pkg::CLK_W-1:0];
		end
	end

	// advance while the output register is empty or being taken
	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;

	pdc_ticks u_ticks (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (in_valid),
		.period   (period_time_ns),
		.duty     (duty_time_ns),
		.clk_mhz  (clk_mhz_q),
		.tk       (tk)
	);

	pdc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.tk      (tk),
		.qo      (qo)
	);

	pdc_pack u_pack (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.qo             (qo),
		.res_valid      (out_valid),
		.status         (status),
		.control_word   (control_word),
		.high_count     (high_count),
		.low_count      (low_count),
		.prescale_shift (prescale_shift)
	);

	assign err_clear = (control_word == '0) && (high_count == '0) && (low_count == '0)
		&& (prescale_shift == '0);
	assign fields_match = (control_word[31:20] == high_count)
		&& (control_word[19:8] == low_count) && (control_word[7:4] == prescale_shift)
		&& (control_word[3:0] == 4'd0);

	`PDC_ASSERT_NOW(a_stall_link, 1'b1, in_stall == (out_valid && out_stall), "in_stall mismatch")
	`PDC_ASSERT_NOW(a_err_zero, out_valid && (status != pdc_pkg::ST_OK), err_clear, "error not cleared")
	`PDC_ASSERT_NOW(a_word_fields, out_valid && (status == pdc_pkg::ST_OK), fields_match, "word fields")
	`PDC_ASSERT_NEXT(a_hold_stall, out_valid && out_stall, out_valid && $stable(control_word), "stall")

endmodule

// ===== src/pdc_ticks.sv =====
// ----------------------------------------------------------------------------
// PWM period to tick conversion
// Three stages: reciprocal partial products, combine, scale by clock in MHz.
// ----------------------------------------------------------------------------
module pdc_ticks (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          in_valid,
	input  logic [pdc_pkg::PER_W-1:0]     period,
	input  logic [pdc_pkg::PER_W-1:0]     duty,
	input  logic [pdc_pkg::CLK_W-1:0]     clk_mhz,
	output pdc_pkg::pdc_tick_t            tk
);

	logic v_s1, v_s2, v_s3;
	logic inv_s1, inv_s2, inv_s3;
	logic long_s1, long_s2;
	logic [pdc_pkg::PER_W-1:0] per_s1, per_s2, per_s3;
	logic [pdc_pkg::PER_W-1:0] duty_s1, duty_s2, duty_s3;
	logic [43:0] pph_s1;
	logic [44:0] ppl_s1;
	logic [17:0] sprod_s1;
	logic [21:0] q_s2;
	logic [8:0]  sticks_s2;
	logic [pdc_pkg::TICK_W-1:0] ticks_s3;

	logic [60:0] long_sum;
	logic [36:0] short_prod;

	assign long_sum   = {1'b0, pph_s1, 16'b0} + 61'(ppl_s1);
	assign short_prod = 37'(sprod_s1) * 37'(pdc_pkg::M_SHORT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inv_s1   <= (period == '0) || (duty > period);
			long_s1  <= period > pdc_pkg::NS_PER_US;
			per_s1   <= period;
			duty_s1  <= duty;
			pph_s1   <= 44'(period[30:16]) * 44'(pdc_pkg::M_LONG);
			ppl_s1   <= 45'(period[15:0]) * 45'(pdc_pkg::M_LONG);
			sprod_s1 <= 18'(period[9:0]) * 18'(clk_mhz);

			inv_s2    <= inv_s1;
			long_s2   <= long_s1;
			per_s2    <= per_s1;
			duty_s2   <= duty_s1;
			q_s2      <= long_sum[59:38];
			sticks_s2 <= short_prod[36:28];

			inv_s3   <= inv_s2;
			per_s3   <= per_s2;
			duty_s3  <= duty_s2;
			ticks_s3 <= long_s2 ? 30'(q_s2) * 30'(clk_mhz) : 30'(sticks_s2);
		end
	end

	assign tk = '{valid: v_s3, invalid: inv_s3, period: per_s3,
		duty: duty_s3, ticks: ticks_s3};

endmodule

// ===== src/pdc_div.sv =====
// ----------------------------------------------------------------------------
// PWM high-count divider
// ticks * duty in two partial products, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module pdc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  pdc_pkg::pdc_tick_t tk,
	output pdc_pkg::pdc_quo_t  qo
);

	localparam int N = pdc_pkg::DIV_STEPS;
	localparam int TW = pdc_pkg::TICK_W;
	localparam int PW = pdc_pkg::PER_W;

	logic v_s4, v_s5;
	logic inv_s4, inv_s5;
	logic [PW-1:0] per_s4, per_s5;
	logic [TW-1:0] ticks_s4, ticks_s5;
	logic [44:0] pdh_s4;
	logic [45:0] pdl_s4;
	logic [pdc_pkg::PROD_W-1:0] num;

	// divider stages, entry k is the output of step k
	logic          v_s6   [1:N];
	logic          inv_s6 [1:N];
	logic [PW-1:0] per_s6 [1:N];
	logic [TW-1:0] tck_s6 [1:N];
	logic [PW-1:0] rem_s6 [1:N];
	logic [TW-1:0] lo_s6  [1:N];
	logic [TW-1:0] q_s6   [1:N];

	assign num = {pdh_s4, 16'b0} + 61'(pdl_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s4 <= tk.valid;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inv_s4   <= tk.invalid;
			per_s4   <= tk.period;
			ticks_s4 <= tk.ticks;
			pdh_s4   <= 45'(tk.ticks) * 45'(tk.duty[30:16]);
			pdl_s4   <= 46'(tk.ticks) * 46'(tk.duty[15:0]);

			inv_s5   <= inv_s4;
			per_s5   <= per_s4;
			ticks_s5 <= ticks_s4;
		end
	end

	logic [PW-1:0] rem_init_s5;
	logic [TW-1:0] lo_init_s5;

	// top bits stay below the period when duty does not exceed it
	always_ff @(posedge clk) begin
		if (advance) begin
			rem_init_s5 <= num[60:30];
			lo_init_s5  <= num[29:0];
		end
	end

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_step
			logic          v_in, inv_in;
			logic [PW-1:0] per_in, rem_in;
			logic [TW-1:0] tck_in, lo_in, q_in;
			logic [PW:0]   trial;
			logic          ge;

			// first step loads from the stage-5 registers
			if (k == 0) begin : g_first
				assign v_in   = v_s5;
				assign inv_in = inv_s5;
				assign per_in = per_s5;
				assign tck_in = ticks_s5;
				assign rem_in = rem_init_s5;
				assign lo_in  = lo_init_s5;
				assign q_in   = '0;
			end else begin : g_next
				assign v_in   = v_s6[k];
				assign inv_in = inv_s6[k];
				assign per_in = per_s6[k];
				assign tck_in = tck_s6[k];
				assign rem_in = rem_s6[k];
				assign lo_in  = lo_s6[k];
				assign q_in   = q_s6[k];
			end

			assign trial  = {rem_in, lo_in[TW-1]};
			assign ge     = trial >= {1'b0, per_in};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s6[k+1] <= 1'b0;
				end else if (advance) begin
					v_s6[k+1] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (advance) begin
					inv_s6[k+1] <= inv_in;
					per_s6[k+1] <= per_in;
					tck_s6[k+1] <= tck_in;
					rem_s6[k+1] <= ge ? PW'(trial - {1'b0, per_in}) : trial[PW-1:0];
					lo_s6[k+1]  <= {lo_in[TW-2:0], 1'b0};
					q_s6[k+1]   <= {q_in[TW-2:0], ge};
				end
			end
		end
	endgenerate

	assign qo = '{valid: v_s6[N], invalid: inv_s6[N], ticks: tck_s6[N], high: q_s6[N]};

endmodule

// ===== src/pdc_pack.sv =====
// ----------------------------------------------------------------------------
// PWM count prescale and pack
// Low count and shift search, then shift, range check and packing.
// ----------------------------------------------------------------------------
module pdc_pack (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  pdc_pkg::pdc_quo_t               qo,
	output logic                            res_valid,
	output logic [1:0]                      status,
	output logic [31:0]                     control_word,
	output logic [11:0]                     high_count,
	output logic [11:0]                     low_count,
	output logic [3:0]                      prescale_shift
);

	localparam int CB = pdc_pkg::COUNT_BITS;
	localparam int TW = pdc_pkg::TICK_W;

	logic v_s7, inv_s7;
	logic [TW-1:0] hi_s7, lo_s7;
	logic [pdc_pkg::TOP_W-1:0] sh_s7;

	logic v_s8;
	logic [1:0] status_s8;
	logic [31:0] word_s8;
	logic [11:0] hc_s8, lc_s8;
	logic [3:0] sh_s8;

	logic [TW-1:0] low_c;
	logic [pdc_pkg::TOP_W-1:0] top_c;
	logic [CB-1:0] hs_c, ls_c;
	logic [47:0] word_c;

	assign low_c = qo.ticks - qo.high;
	// the larger count sets the shift, so search the OR of both
	assign top_c = pdc_pkg::top_bit(qo.high | low_c);
	assign hs_c  = CB'(hi_s7 >> sh_s7);
	assign ls_c  = CB'(lo_s7 >> sh_s7);
	assign word_c = (48'(hs_c) << pdc_pkg::HIGH_POS) | (48'(ls_c) << pdc_pkg::LOW_POS)
		| (48'(sh_s7) << pdc_pkg::SHIFT_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (advance) begin
			v_s7 <= qo.valid;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inv_s7 <= qo.invalid;
			hi_s7  <= qo.high;
			lo_s7  <= low_c;
			sh_s7  <= (top_c > pdc_pkg::TOP_W'(CB)) ? top_c - pdc_pkg::TOP_W'(CB) : '0;

			if (inv_s7) begin
				status_s8 <= pdc_pkg::ST_INVALID;
				word_s8   <= '0;
				hc_s8     <= '0;
				lc_s8     <= '0;
				sh_s8     <= '0;
			end else if (sh_s7 > pdc_pkg::MAX_SHIFT) begin
				status_s8 <= pdc_pkg::ST_OVERFLOW;
				word_s8   <= '0;
				hc_s8     <= '0;
				lc_s8     <= '0;
				sh_s8     <= '0;
			end else begin
				status_s8 <= pdc_pkg::ST_OK;
				word_s8   <= word_c[31:0];
				hc_s8     <= 12'(hs_c);
				lc_s8     <= 12'(ls_c);
				sh_s8     <= sh_s7[3:0];
			end
		end
	end

	assign res_valid      = v_s8;
	assign status         = status_s8;
	assign control_word   = word_s8;
	assign high_count     = hc_s8;
	assign low_count      = lc_s8;
	assign prescale_shift = sh_s8;

endmodule

// ===== tb/pwm_period_duty_to_counts_checker.sv =====
// ----------------------------------------------------------------------------
// PWM counts checker
// Watches the request and result channels, computes the expected counter
// settings for every accepted request and compares each delivered result.
// ----------------------------------------------------------------------------
module pwm_period_duty_to_counts_checker
	import pdc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [1:0]       paddr,
	input  logic [31:0]      pwdata,
	input  logic             pready,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [PER_W-1:0] period_time_ns,
	input  logic [PER_W-1:0] duty_time_ns,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [1:0]       status,
	input  logic [31:0]      control_word,
	input  logic [11:0]      high_count,
	input  logic [11:0]      low_count,
	input  logic [3:0]       prescale_shift,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t     st;
		logic [31:0] word;
		logic [11:0] hi;
		logic [11:0] lo;
		logic [3:0]  sh;
	} counts_t;

	counts_t           expected_counts[$];
	logic [CLK_W-1:0]  clock_mhz;

	function automatic int bits_over(input logic [63:0] v);
		int n;
		n = 0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) n = i + 1;
		end
		return (n > COUNT_BITS) ? n - COUNT_BITS : 0;
	endfunction

	function automatic counts_t convert_request(input logic [PER_W-1:0] per,
			input logic [PER_W-1:0] duty, input logic [CLK_W-1:0] mhz);
		counts_t r;
		logic [63:0] ticks, hi, lo;
		int s;
		r = '0;
		r.st = ST_OK;
		if (per == 0 || duty > per) begin
			r.st = ST_INVALID;
			return r;
		end
		if (per > 1000) ticks = (64'(per) / 1000) * 64'(mhz);
		else ticks = (64'(per) * 64'(mhz)) / 1000;
		hi = (ticks * 64'(duty)) / 64'(per);
		lo = ticks - hi;
		s = bits_over(hi);
		if (bits_over(lo) > s) s = bits_over(lo);
		if (s > 15) begin
			r.st = ST_OVERFLOW;
			return r;
		end
		hi = hi >> s;
		lo = lo >> s;
		r.word = 32'((hi << HIGH_POS) | (lo << LOW_POS) | (64'(s) << SHIFT_POS));
		r.hi = hi[11:0];
		r.lo = lo[11:0];
		r.sh = 4'(s);
		return r;
	endfunction

	assign pending = expected_counts.size();

	always @(posedge clk or negedge arst_n) begin
		counts_t e;
		if (!arst_n) begin
			clock_mhz <= CLK_RESET;
			fail_count = 0;
			expected_counts.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_CLK_MHZ)
				clock_mhz <= pwdata[7:0];
			if (in_valid && !in_stall)
				expected_counts.push_back(convert_request(period_time_ns,
					duty_time_ns, clock_mhz));
			if (out_valid && !out_stall) begin
				if (expected_counts.size() == 0) begin
					$error("unexpected result word");
					fail_count++;
				end else begin
					e = expected_counts.pop_front();
					if (status !== e.st) begin
						$error("status exp %0d got %0d", e.st, status);
						fail_count++;
					end
					if (control_word !== e.word) begin
						$error("control_word exp %h got %h", e.word, control_word);
						fail_count++;
					end
					if (high_count !== e.hi) begin
						$error("high_count exp %0d got %0d", e.hi, high_count);
						fail_count++;
					end
					if (low_count !== e.lo) begin
						$error("low_count exp %0d got %0d", e.lo, low_count);
						fail_count++;
					end
					if (prescale_shift !== e.sh) begin
						$error("prescale_shift exp %0d got %0d", e.sh, prescale_shift);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ===== tb/pwm_period_duty_to_counts_unit_tb.sv =====
// ----------------------------------------------------------------------------
// PWM counts unit testbench
// Drives directed and random period/duty requests under several source
// clock settings, with bursty input and random output stalls.
// ----------------------------------------------------------------------------
module pwm_period_duty_to_counts_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pdc_pkg::*;

	localparam int         ITEMS      = 1950;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0]       paddr = '0;
	logic [31:0]      pwdata = '0;
	logic [31:0]      prdata;
	logic             pready;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [PER_W-1:0] period_time_ns = '0, duty_time_ns = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       status;
	logic [31:0]      control_word;
	logic [11:0]      high_count, low_count;
	logic [3:0]       prescale_shift;
	int               fail_count, pending;
	bit               stall_on = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pwm_period_duty_to_counts_unit u_dut (.*);

	pwm_period_duty_to_counts_checker u_check (.*);

	// receiver stall pattern: toggles between stall-free and stalling runs
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
		out_stall <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b0;
	end

	task automatic write_clock(input logic [7:0] mhz);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_CLK_MHZ; pwdata <= {24'h0, mhz};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0 || in_valid) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	// send one word, keeping valid high if another follows back to back
	task automatic send_word(input logic [30:0] per, input logic [30:0] duty,
			input bit hold_valid);
		in_valid <= 1'b1;
		period_time_ns <= per;
		duty_time_ns <= duty;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (!hold_valid) in_valid <= 1'b0;
	endtask

	function automatic logic [30:0] rand_period();
		case ($urandom_range(0, 5))
			0: return 31'($urandom_range(0, 1000));
			1: return 31'($urandom_range(1001, 100000));
			2: return 31'($urandom_range(1, 20));
			3: return 31'($urandom) | 31'h4000_0000;
			default: return 31'($urandom) >> $urandom_range(0, 30);
		endcase
	endfunction

	task automatic random_block(input int n);
		int gap, burst;
		logic [30:0] per, duty;
		while (n > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && n > 0) begin
				per = rand_period();
				case ($urandom_range(0, 7))
					0: duty = 31'($urandom);
					1: duty = per;
					2: duty = 0;
					3: duty = per + 31'($urandom_range(1, 3));
					default: duty = (per == 0) ? 31'd0 : 31'($urandom) % (per + 1);
				endcase
				send_word(per, duty, burst > 1 && n > 1);
				burst--;
				n--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		logic [7:0] clocks[5] = '{8'd1, 8'd255, 8'd0, 8'd50, 8'd96};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: reset clock of 96
		send_word(31'd0, 31'd0, 1);
		send_word(31'd100, 31'd101, 1);
		send_word(31'd1000, 31'd500, 1);
		send_word(31'd1001, 31'd1001, 1);
		send_word(31'd999, 31'd0, 1);
		send_word(31'h7FFF_FFFF, 31'h7FFF_FFFF, 1);
		send_word(31'h7FFF_FFFF, 31'd0, 1);
		send_word(31'h7FFF_FFFF, 31'h3FFF_FFFF, 1);
		send_word(31'd1, 31'd1, 1);
		send_word(31'd42700, 31'd42699, 1);
		send_word(31'd12345678, 31'd1234567, 0);
		drain();
		write_clock(8'd255);
		send_word(31'h7FFF_FFFF, 31'h5555_5555, 1);
		send_word(31'd16063, 31'd8000, 1);
		send_word(31'd1000, 31'd1000, 0);
		drain();
		write_clock(8'd0);
		send_word(31'd5000000, 31'd2500000, 1);
		send_word(31'd10, 31'd11, 0);
		drain();
		for (int p = 0; p < 5; p++) begin
			write_clock(clocks[p]);
			random_block(ITEMS / 10);
			// hold off until every result is back
			drain();
			write_clock(8'($urandom_range(1, 255)));
			random_block(ITEMS / 10);
			drain();
		end
		if (fail_count == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
